### hw/rtl/sdspi_pkg.sv
// ----------------------------------------------------------------------------
// SD SPI host sequencer package
// Shared widths, action and status codes, and the item and result types.
// ----------------------------------------------------------------------------
`default_nettype none

package sdspi_pkg;

  localparam int SectorBytes     = 512;
  localparam int DummyClockBytes = 10;

  localparam int ActionW = 2;
  localparam int AddrW   = 32;
  localparam int ByteW   = 8;
  localparam int StatusW = 2;
  localparam int LenW    = 10;

  // counter and held length must reach both the sector size and any read length
  localparam int CntW = ($clog2(SectorBytes + 1) > LenW) ? $clog2(SectorBytes + 1) : LenW;

  localparam logic [ActionW-1:0] ActExchange = 2'd0;
  localparam logic [ActionW-1:0] ActInit     = 2'd1;
  localparam logic [ActionW-1:0] ActWrite    = 2'd2;
  localparam logic [ActionW-1:0] ActRead     = 2'd3;

  localparam logic [StatusW-1:0] StatusOk         = 2'd0;
  localparam logic [StatusW-1:0] StatusIdleFail   = 2'd1;
  localparam logic [StatusW-1:0] StatusCmdReject  = 2'd2;
  localparam logic [StatusW-1:0] StatusDataReject = 2'd3;

  localparam logic [LenW-1:0] ReadLenReset = 10'd512;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [AddrW-1:0]   block_address;
    logic [ByteW-1:0]   rx_byte;
    logic [ByteW-1:0]   write_byte;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0]   tx_byte;
    logic               tx_valid;
    logic               card_select;
    logic [ByteW-1:0]   read_byte;
    logic               read_valid;
    logic               data_request;
    logic               done_res;
    logic [StatusW-1:0] status;
    logic [ByteW-1:0]   response_byte;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/sdspi_if.sv
// ----------------------------------------------------------------------------
// SD SPI host sequencer channels
// Input item, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdspi_in_if;
  logic                          valid;
  logic                          ready;
  logic [sdspi_pkg::ActionW-1:0] action;
  logic [sdspi_pkg::AddrW-1:0]   block_address;
  logic [sdspi_pkg::ByteW-1:0]   rx_byte;
  logic [sdspi_pkg::ByteW-1:0]   write_byte;

  modport source (output valid, action, block_address, rx_byte, write_byte, input ready);
  modport sink   (input valid, action, block_address, rx_byte, write_byte, output ready);
endinterface

interface sdspi_out_if;
  logic                          valid;
  logic                          ready;
  logic [sdspi_pkg::ByteW-1:0]   tx_byte;
  logic                          tx_valid;
  logic                          card_select;
  logic [sdspi_pkg::ByteW-1:0]   read_byte;
  logic                          read_valid;
  logic                          data_request;
  logic                          done_res;
  logic [sdspi_pkg::StatusW-1:0] status;
  logic [sdspi_pkg::ByteW-1:0]   response_byte;

  modport source (output valid, tx_byte, tx_valid, card_select, read_byte, read_valid,
                  data_request, done_res, status, response_byte, input ready);
  modport sink   (input valid, tx_byte, tx_valid, card_select, read_byte, read_valid,
                  data_request, done_res, status, response_byte, output ready);
endinterface

interface sdspi_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [sdspi_pkg::LenW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/sd_spi_host_sequencer.sv
// ----------------------------------------------------------------------------
// SD card SPI-mode host sequencer
// Runs card init, single-sector write and block read, one byte exchange per item.
// ----------------------------------------------------------------------------
// An input transfer passes the input register, then the result register, to result valid.
// One item per cycle while out_ch is ready; the result register refills while it is taken.
// The sequencer core's state update and frame mux form the path between the two registers.
// Reset: sequencer idle, card deselected, read block length 512, both stages empty.
`default_nettype none

module sd_spi_host_sequencer (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sdspi_in_if.sink   in_ch,
  sdspi_out_if.source out_ch,
  sdspi_cfg_if.sink  cfg_ch
);
  import sdspi_pkg::*;

  logic            s1_vld;
  in_item_t        s1_item;
  logic            adv;
  result_t         res;
  result_t         out_q;
  logic            out_vld_q, out_vld_d;
  logic [LenW-1:0] read_len_q;

  assign adv = s1_vld && (!out_vld_q || out_ch.ready);

  sdspi_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .adv_i   (adv),
    .item_o  (s1_item),
    .valid_o (s1_vld)
  );

  sdspi_seq_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (s1_item),
    .fire_i     (adv),
    .read_len_i (read_len_q),
    .res_o      (res)
  );

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      read_len_q <= ReadLenReset;
    end else begin
      out_vld_q <= out_vld_d;
      if (cfg_ch.valid) begin
        read_len_q <= cfg_ch.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_ch.valid         = out_vld_q;
  assign out_ch.tx_byte       = out_q.tx_byte;
  assign out_ch.tx_valid      = out_q.tx_valid;
  assign out_ch.card_select   = out_q.card_select;
  assign out_ch.read_byte     = out_q.read_byte;
  assign out_ch.read_valid    = out_q.read_valid;
  assign out_ch.data_request  = out_q.data_request;
  assign out_ch.done_res      = out_q.done_res;
  assign out_ch.status        = out_q.status;
  assign out_ch.response_byte = out_q.response_byte;

  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("result register not loaded after advance");

  a_no_adv_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |-> s1_vld)
    else $error("advance from an empty input stage");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ch.ready |=> out_vld_q && $stable(out_q))
    else $error("pending result changed while stalled");

endmodule

`default_nettype wire

### hw/rtl/sdspi_in_stage.sv
// ----------------------------------------------------------------------------
// SD SPI input stage
// Registers one accepted item; refills in the cycle the held item moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module sdspi_in_stage (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  sdspi_in_if.sink             in_ch,
  input  wire logic            adv_i,
  output sdspi_pkg::in_item_t  item_o,
  output logic                 valid_o
);
  import sdspi_pkg::*;

  logic     vld_q, vld_d;
  in_item_t item_q;
  logic     take;

  assign in_ch.ready = !vld_q || adv_i;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (adv_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= '{action:        in_ch.action,
                  block_address: in_ch.block_address,
                  rx_byte:       in_ch.rx_byte,
                  write_byte:    in_ch.write_byte};
    end
  end

  assign item_o  = item_q;
  assign valid_o = vld_q;

endmodule

`default_nettype wire

### hw/rtl/sdspi_seq_core.sv
// ----------------------------------------------------------------------------
// SD SPI sequencer core
// Transaction state and the per-transfer next-state and result logic.
// ----------------------------------------------------------------------------
`default_nettype none

module sdspi_seq_core (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire sdspi_pkg::in_item_t   item_i,
  input  wire logic                  fire_i,
  input  wire logic [sdspi_pkg::LenW-1:0] read_len_i,
  output sdspi_pkg::result_t         res_o
);
  import sdspi_pkg::*;

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StDummy  = 4'd1;
  localparam logic [3:0] StCmd    = 4'd2;
  localparam logic [3:0] StWGap   = 4'd3;
  localparam logic [3:0] StWToken = 4'd4;
  localparam logic [3:0] StWData  = 4'd5;
  localparam logic [3:0] StWCrc   = 4'd6;
  localparam logic [3:0] StWResp  = 4'd7;
  localparam logic [3:0] StWBusy  = 4'd8;
  localparam logic [3:0] StRWait  = 4'd9;
  localparam logic [3:0] StRData  = 4'd10;
  localparam logic [3:0] StRCrc   = 4'd11;

  localparam logic [5:0] CmdGoIdle  = 6'd0;
  localparam logic [5:0] CmdOpCond  = 6'd1;
  localparam logic [5:0] CmdSetBlen = 6'd16;
  localparam logic [5:0] CmdRead    = 6'd17;
  localparam logic [5:0] CmdWrite   = 6'd24;
  localparam logic [5:0] CmdCrcOff  = 6'd59;

  localparam logic [3:0] FrameLast = 4'd8;

  localparam logic [ByteW-1:0] ByteIdle  = 8'hFF;
  localparam logic [ByteW-1:0] ByteToken = 8'hFE;
  localparam logic [ByteW-1:0] ByteCrc   = 8'h95;
  localparam logic [ByteW-1:0] CmdPrefix = 8'h40;
  localparam logic [ByteW-1:0] R1Idle    = 8'h01;
  localparam logic [ByteW-1:0] R1Ready   = 8'h00;
  localparam logic [4:0]       RespMask  = 5'h1F;
  localparam logic [4:0]       RespOk    = 5'h05;

  logic [3:0]       step_q, step_d;
  logic [1:0]       op_q, op_d;
  logic [3:0]       pos_q, pos_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [AddrW-1:0] arg_q, arg_d;
  logic [5:0]       idx_q, idx_d;
  logic             sel_q, sel_d;
  logic [AddrW-1:0] haddr_q, haddr_d;
  logic [CntW-1:0]  hlen_q, hlen_d;

  logic [CntW-1:0]  cnt_inc;
  result_t          res;

  function automatic logic [ByteW-1:0] frame_byte(input logic [3:0]       pos,
                                                  input logic [5:0]       idx,
                                                  input logic [AddrW-1:0] arg);
    logic [ByteW-1:0] b;
    unique case (pos)
      4'd1:    b = CmdPrefix | {2'b00, idx};
      4'd2:    b = arg[31:24];
      4'd3:    b = arg[23:16];
      4'd4:    b = arg[15:8];
      4'd5:    b = arg[7:0];
      4'd6:    b = ByteCrc;
      default: b = ByteIdle;
    endcase
    return b;
  endfunction

  assign cnt_inc = cnt_q + 1'b1;

  always_comb begin
    step_d  = step_q;
    op_d    = op_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    arg_d   = arg_q;
    idx_d   = idx_q;
    sel_d   = sel_q;
    haddr_d = haddr_q;
    hlen_d  = hlen_q;
    res     = '0;

    if (item_i.action != ActExchange) begin
      op_d  = item_i.action;
      cnt_d = '0;
      pos_d = '0;
      if (item_i.action == ActInit) begin
        sel_d  = 1'b0;
        step_d = StDummy;
      end else begin
        sel_d = 1'b1;
        if (item_i.action == ActWrite) begin
          hlen_d  = CntW'(SectorBytes);
          haddr_d = item_i.block_address * AddrW'(SectorBytes);
        end else begin
          hlen_d  = CntW'(read_len_i);
          haddr_d = item_i.block_address * AddrW'(read_len_i);
        end
        step_d = StCmd;
        idx_d  = CmdSetBlen;
        arg_d  = AddrW'(hlen_d);
      end
    end else begin
      unique case (step_q)
        StDummy: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= CntW'(DummyClockBytes)) begin
            sel_d  = 1'b1;
            step_d = StCmd;
            pos_d  = '0;
            idx_d  = CmdGoIdle;
            arg_d  = '0;
          end
        end
        StCmd: begin
          if (pos_q < FrameLast) begin
            pos_d = pos_q + 1'b1;
          end else begin
            // frame done: rx_byte is the R1
            pos_d = '0;
            unique case (idx_q)
              CmdGoIdle: begin
                if (item_i.rx_byte != R1Idle) begin
                  step_d            = StIdle;
                  res.done_res      = 1'b1;
                  res.status        = StatusIdleFail;
                  res.response_byte = item_i.rx_byte;
                end else begin
                  idx_d = CmdOpCond;
                  arg_d = '0;
                end
              end
              CmdOpCond: begin
                idx_d = (item_i.rx_byte != R1Ready) ? CmdOpCond : CmdCrcOff;
                arg_d = '0;
              end
              CmdCrcOff: begin
                idx_d = CmdSetBlen;
                arg_d = AddrW'(SectorBytes);
              end
              CmdSetBlen: begin
                if (op_q == ActWrite) begin
                  idx_d = CmdWrite;
                  arg_d = haddr_q;
                end else if (op_q == ActRead) begin
                  idx_d = CmdRead;
                  arg_d = haddr_q;
                end else begin
                  step_d       = StIdle;
                  res.done_res = 1'b1;
                end
              end
              CmdWrite: begin
                if (item_i.rx_byte != R1Ready) begin
                  step_d            = StIdle;
                  res.done_res      = 1'b1;
                  res.status        = StatusCmdReject;
                  res.response_byte = item_i.rx_byte;
                end else begin
                  step_d = StWGap;
                  cnt_d  = '0;
                end
              end
              default: begin
                step_d = StRWait;
                cnt_d  = '0;
              end
            endcase
          end
        end
        StWGap: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= CntW'(2)) begin
            step_d = StWToken;
          end
        end
        StWToken: begin
          step_d = StWData;
          cnt_d  = '0;
        end
        StWData: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= CntW'(SectorBytes)) begin
            step_d = StWCrc;
            cnt_d  = '0;
          end
        end
        StWCrc: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= CntW'(2)) begin
            step_d = StWResp;
          end
        end
        StWResp: begin
          if ((item_i.rx_byte[4:0] & RespMask) != RespOk) begin
            step_d            = StIdle;
            res.done_res      = 1'b1;
            res.status        = StatusDataReject;
            res.response_byte = item_i.rx_byte;
          end else begin
            step_d = StWBusy;
          end
        end
        StWBusy: begin
          if (item_i.rx_byte == ByteIdle) begin
            step_d       = StIdle;
            res.done_res = 1'b1;
          end
        end
        StRWait: begin
          if (item_i.rx_byte == ByteToken) begin
            cnt_d  = '0;
            step_d = (hlen_q == '0) ? StRCrc : StRData;
          end
        end
        StRData: begin
          res.read_byte  = item_i.rx_byte;
          res.read_valid = 1'b1;
          cnt_d          = cnt_inc;
          if (cnt_inc >= hlen_q) begin
            step_d = StRCrc;
            cnt_d  = '0;
          end
        end
        StRCrc: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= CntW'(2)) begin
            step_d       = StIdle;
            res.done_res = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    res.card_select = sel_d;
    if (step_d != StIdle) begin
      res.tx_valid = 1'b1;
      unique case (step_d)
        StCmd:    res.tx_byte = frame_byte(pos_d, idx_d, arg_d);
        StWToken: begin
          res.tx_byte      = ByteToken;
          res.data_request = 1'b1;
        end
        StWData: begin
          res.tx_byte      = item_i.write_byte;
          res.data_request = ({1'b0, cnt_d} + 1'b1) < (CntW + 1)'(SectorBytes);
        end
        default:  res.tx_byte = ByteIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= StIdle;
      op_q    <= '0;
      pos_q   <= '0;
      cnt_q   <= '0;
      arg_q   <= '0;
      idx_q   <= '0;
      sel_q   <= 1'b0;
      haddr_q <= '0;
      hlen_q  <= '0;
    end else if (fire_i) begin
      step_q  <= step_d;
      op_q    <= op_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      arg_q   <= arg_d;
      idx_q   <= idx_d;
      sel_q   <= sel_d;
      haddr_q <= haddr_d;
      hlen_q  <= hlen_d;
    end
  end

  assign res_o = res;

  a_done_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res.done_res |=> step_q == StIdle)
    else $error("transaction end did not return to idle");

  a_dreq_selected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res.data_request |-> res.tx_valid && res.card_select)
    else $error("data request without a selected exchange");

  a_read_data_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res.read_valid |-> op_q == ActRead)
    else $error("read data outside a block read");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(step_q) && $stable(cnt_q) && $stable(pos_q))
    else $error("sequencer state moved without a transfer");

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// SD SPI host sequencer testbench
// Plays a card answering init, sector write and block read sequences, with
// random stalls on both channels and read length changes between phases.
// Every result is checked against a cycle-free model of the sequencer.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sdspi_pkg::*;

  localparam int CycleLimit = 1_000_000;
  localparam int GapMax     = 17;

  localparam logic [5:0] CmdGoIdle      = 6'd0;
  localparam logic [5:0] CmdOpCond      = 6'd1;
  localparam logic [5:0] CmdSetBlockLen = 6'd16;
  localparam logic [5:0] CmdReadSingle  = 6'd17;
  localparam logic [5:0] CmdWriteBlock  = 6'd24;
  localparam logic [5:0] CmdCrcOnOff    = 6'd59;

  localparam logic [7:0] CmdPrefix    = 8'h40;
  localparam logic [7:0] CrcByte      = 8'h95;
  localparam logic [7:0] FillByte     = 8'hFF;
  localparam logic [7:0] StartToken   = 8'hFE;
  localparam logic [7:0] R1Idle       = 8'h01;
  localparam logic [7:0] R1Ready      = 8'h00;
  localparam logic [4:0] RespMask     = 5'h1F;
  localparam logic [4:0] DataAccepted = 5'h05;

  typedef enum logic [5:0] {
    StIdle, StDummy, StCmd, StWGap, StWToken, StWData, StWCrc, StWResp, StWBusy,
    StRWait, StRData, StRCrc
  } seq_step_e;

  typedef struct packed {
    seq_step_e          step;
    logic [ActionW-1:0] op;
    logic [3:0]         fpos;
    logic [CntW-1:0]    cnt;
    logic [AddrW-1:0]   arg;
    logic [5:0]         idx;
    logic               sel;
    logic [AddrW-1:0]   held_addr;
    logic [CntW-1:0]    held_len;
    logic [LenW-1:0]    rd_len;
  } seq_state_t;

  logic clk_i;
  logic rst_ni;

  sdspi_in_if  in_ch ();
  sdspi_out_if out_ch ();
  sdspi_cfg_if cfg_ch ();

  sd_spi_host_sequencer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  seq_state_t dut_view;   // advanced on accepted transfers
  seq_state_t card_view;  // advanced while items are planned
  in_item_t   pending_items[$];
  result_t    expected_results[$];

  bit card_obliging;      // card accepts the write command, no random restarts

  int planned_items;
  int phase_items;
  int items_sent;
  int results_seen;
  int errors;
  int send_idle_pct;
  int recv_idle_pct;
  int send_gap;
  int recv_gap;
  int hold_left;
  int cycles;

  // --------------------------------------------------------------------------
  // sequencer model
  // --------------------------------------------------------------------------
  function automatic seq_state_t reset_state();
    seq_state_t s;
    s = '0;
    s.step   = StIdle;
    s.rd_len = ReadLenReset;
    return s;
  endfunction

  function automatic void issue_cmd(inout seq_state_t s, input logic [5:0] idx,
                                    input logic [AddrW-1:0] arg);
    s.step = StCmd;
    s.fpos = '0;
    s.idx  = idx;
    s.arg  = arg;
  endfunction

  function automatic void close_transfer(inout seq_state_t s, inout result_t r,
                                         input logic [StatusW-1:0] st,
                                         input logic [ByteW-1:0] resp);
    s.step          = StIdle;
    r.done_res      = 1'b1;
    r.status        = st;
    r.response_byte = resp;
  endfunction

  function automatic void command_done(inout seq_state_t s, inout result_t r,
                                       input logic [ByteW-1:0] r1);
    case (s.idx)
      CmdGoIdle: begin
        if (r1 != R1Idle) close_transfer(s, r, StatusIdleFail, r1);
        else issue_cmd(s, CmdOpCond, '0);
      end
      CmdOpCond: begin
        if (r1 != R1Ready) issue_cmd(s, CmdOpCond, '0);
        else issue_cmd(s, CmdCrcOnOff, '0);
      end
      CmdCrcOnOff: issue_cmd(s, CmdSetBlockLen, AddrW'(SectorBytes));
      CmdSetBlockLen: begin
        if (s.op == ActWrite) issue_cmd(s, CmdWriteBlock, s.held_addr);
        else if (s.op == ActRead) issue_cmd(s, CmdReadSingle, s.held_addr);
        else close_transfer(s, r, StatusOk, '0);
      end
      CmdWriteBlock: begin
        if (r1 != R1Ready) close_transfer(s, r, StatusCmdReject, r1);
        else begin
          s.step = StWGap;
          s.cnt  = '0;
        end
      end
      default: begin
        // read R1 is not inspected
        s.step = StRWait;
        s.cnt  = '0;
      end
    endcase
  endfunction

  function automatic logic [ByteW-1:0] frame_byte(input seq_state_t s);
    case (s.fpos)
      4'd1:    return CmdPrefix | {2'b00, s.idx};
      4'd2:    return s.arg[31:24];
      4'd3:    return s.arg[23:16];
      4'd4:    return s.arg[15:8];
      4'd5:    return s.arg[7:0];
      4'd6:    return CrcByte;
      default: return FillByte;
    endcase
  endfunction

  function automatic result_t sequencer_step(inout seq_state_t s, input in_item_t it);
    result_t r;
    r = '0;
    if (it.action != ActExchange) begin
      // a start always wins, even over a running transaction
      s.op   = it.action;
      s.cnt  = '0;
      s.fpos = '0;
      if (it.action == ActInit) begin
        s.sel  = 1'b0;
        s.step = StDummy;
      end else begin
        s.sel = 1'b1;
        if (it.action == ActWrite) begin
          s.held_len  = CntW'(SectorBytes);
          s.held_addr = it.block_address * AddrW'(SectorBytes);
        end else begin
          s.held_len  = CntW'(s.rd_len);
          s.held_addr = it.block_address * AddrW'(s.rd_len);
        end
        issue_cmd(s, CmdSetBlockLen, AddrW'(s.held_len));
      end
    end else begin
      case (s.step)
        StDummy: begin
          s.cnt = s.cnt + 1'b1;
          if (int'(s.cnt) >= DummyClockBytes) begin
            s.sel = 1'b1;
            issue_cmd(s, CmdGoIdle, '0);
          end
        end
        StCmd: begin
          if (s.fpos < 4'd8) s.fpos = s.fpos + 1'b1;
          else command_done(s, r, it.rx_byte);
        end
        StWGap: begin
          s.cnt = s.cnt + 1'b1;
          if (s.cnt >= 2) s.step = StWToken;
        end
        StWToken: begin
          s.step = StWData;
          s.cnt  = '0;
        end
        StWData: begin
          s.cnt = s.cnt + 1'b1;
          if (int'(s.cnt) >= SectorBytes) begin
            s.step = StWCrc;
            s.cnt  = '0;
          end
        end
        StWCrc: begin
          s.cnt = s.cnt + 1'b1;
          if (s.cnt >= 2) s.step = StWResp;
        end
        StWResp: begin
          if ((it.rx_byte[4:0] & RespMask) != DataAccepted)
            close_transfer(s, r, StatusDataReject, it.rx_byte);
          else s.step = StWBusy;
        end
        StWBusy: begin
          if (it.rx_byte == FillByte) close_transfer(s, r, StatusOk, '0);
        end
        StRWait: begin
          if (it.rx_byte == StartToken) begin
            s.cnt  = '0;
            s.step = (s.held_len == '0) ? StRCrc : StRData;
          end
        end
        StRData: begin
          r.read_byte  = it.rx_byte;
          r.read_valid = 1'b1;
          s.cnt = s.cnt + 1'b1;
          if (s.cnt >= s.held_len) begin
            s.step = StRCrc;
            s.cnt  = '0;
          end
        end
        StRCrc: begin
          s.cnt = s.cnt + 1'b1;
          if (s.cnt >= 2) close_transfer(s, r, StatusOk, '0);
        end
        default: ;
      endcase
    end

    if (s.step != StIdle) begin
      r.tx_valid = 1'b1;
      case (s.step)
        StCmd: r.tx_byte = frame_byte(s);
        StWToken: begin
          r.tx_byte      = StartToken;
          r.data_request = 1'b1;
        end
        StWData: begin
          r.tx_byte      = it.write_byte;
          r.data_request = (int'(s.cnt) + 1 < SectorBytes);
        end
        default: r.tx_byte = FillByte;
      endcase
    end
    r.card_select = s.sel;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // card side: mostly plausible answers, sometimes garbage
  // --------------------------------------------------------------------------
  function automatic logic [ByteW-1:0] card_reply(input seq_state_t s);
    logic [ByteW-1:0] b;
    b = ByteW'($urandom);
    case (s.step)
      StCmd: begin
        if (s.fpos == 4'd8) begin
          case (s.idx)
            CmdGoIdle: if ($urandom_range(0, 9) != 0) b = R1Idle;
            CmdOpCond: if ($urandom_range(0, 9) < 7) b = R1Ready;
            CmdWriteBlock: if (card_obliging || $urandom_range(0, 9) < 7) b = R1Ready;
            default: ;
          endcase
        end
      end
      StRWait: if ($urandom_range(0, 2) == 0) b = StartToken;
      StWResp: if ($urandom_range(0, 4) != 0) b = {b[7:5], DataAccepted};
      StWBusy: if ($urandom_range(0, 2) == 0) b = FillByte;
      default: ;
    endcase
    return b;
  endfunction

  function automatic logic [AddrW-1:0] rand_addr();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return AddrW'($urandom);
    endcase
  endfunction

  function automatic int draw_gap(input int pct);
    if ($urandom_range(0, 99) < pct) return $urandom_range(0, GapMax);
    return 0;
  endfunction

  task automatic push_item(input in_item_t it);
    result_t ignored;
    if (!(it.action == ActExchange && card_view.step == StIdle)) phase_items++;
    ignored = sequencer_step(card_view, it);
    pending_items.push_back(it);
    planned_items++;
  endtask

  task automatic queue_item(input logic [ActionW-1:0] act);
    in_item_t it;
    it.action        = act;
    it.block_address = (act == ActExchange) ? AddrW'($urandom) : rand_addr();
    it.rx_byte       = (act == ActExchange) ? card_reply(card_view) : ByteW'($urandom);
    it.write_byte    = ByteW'($urandom);
    push_item(it);
  endtask

  task automatic finish_transaction();
    while (card_view.step != StIdle) begin
      if (!card_obliging && $urandom_range(0, 299) == 0)
        queue_item($urandom_range(0, 1) ? ActInit : ActRead);
      else queue_item(ActExchange);
    end
  endtask

  task automatic run_transaction(input logic [ActionW-1:0] act);
    queue_item(act);
    finish_transaction();
  endtask

  task automatic random_phase(input int budget);
    int pick;
    phase_items = 0;
    while (phase_items < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) run_transaction(ActInit);
      else if (pick < 72) run_transaction(ActRead);
      else if (pick < 80) begin
        // drop a sector write partway with a new start
        queue_item(ActWrite);
        repeat ($urandom_range(10, 40)) queue_item(ActExchange);
        run_transaction(ActRead);
      end else begin
        // exchanges, then a start that the next start may cut short
        repeat ($urandom_range(1, 3)) queue_item(ActExchange);
        queue_item(ActionW'($urandom_range(1, 3)));
        repeat ($urandom_range(0, 12)) queue_item(ActExchange);
      end
    end
    if (card_view.step != StIdle && card_view.op == ActWrite) queue_item(ActRead);
    finish_transaction();
  endtask

  task automatic drain();
    while (items_sent != planned_items || expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_read_length(input logic [LenW-1:0] len);
    @(posedge clk_i);
    cfg_ch.data  <= len;
    cfg_ch.valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    dut_view.rd_len  = len;
    card_view.rd_len = len;
  endtask

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned got_v);
    if (exp_v != got_v) begin
      errors++;
      $display("%0t: result %0d %s expected 0x%0h actual 0x%0h",
               $realtime, results_seen, name, exp_v, got_v);
    end
  endfunction

  function automatic void check_result(input result_t exp_r, input result_t got);
    check_field("tx_byte", exp_r.tx_byte, got.tx_byte);
    check_field("tx_valid", exp_r.tx_valid, got.tx_valid);
    check_field("card_select", exp_r.card_select, got.card_select);
    check_field("read_byte", exp_r.read_byte, got.read_byte);
    check_field("read_valid", exp_r.read_valid, got.read_valid);
    check_field("data_request", exp_r.data_request, got.data_request);
    check_field("done_res", exp_r.done_res, got.done_res);
    check_field("status", exp_r.status, got.status);
    check_field("response_byte", exp_r.response_byte, got.response_byte);
  endfunction

  // --------------------------------------------------------------------------
  // clock, reset, limit
  // --------------------------------------------------------------------------
  initial begin
    clk_i               = 1'b0;
    rst_ni              = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.action        = ActExchange;
    in_ch.block_address = '0;
    in_ch.rx_byte       = '0;
    in_ch.write_byte    = '0;
    out_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.data         = '0;
    fork
      forever #4 clk_i = ~clk_i;
      begin
        repeat (4) @(posedge clk_i);
        rst_ni <= 1'b1;
      end
    join_none
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // driver: one transfer per pending item, random gaps in between
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    in_item_t item;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        item.action        = in_ch.action;
        item.block_address = in_ch.block_address;
        item.rx_byte       = in_ch.rx_byte;
        item.write_byte    = in_ch.write_byte;
        expected_results.push_back(sequencer_step(dut_view, item));
        items_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          item = pending_items.pop_front();
          in_ch.action        <= item.action;
          in_ch.block_address <= item.block_address;
          in_ch.rx_byte       <= item.rx_byte;
          in_ch.write_byte    <= item.write_byte;
          in_ch.valid         <= 1'b1;
          send_gap = draw_gap(send_idle_pct);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: take results, stall at random, hold off twice for a long stretch
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        got.tx_byte       = out_ch.tx_byte;
        got.tx_valid      = out_ch.tx_valid;
        got.card_select   = out_ch.card_select;
        got.read_byte     = out_ch.read_byte;
        got.read_valid    = out_ch.read_valid;
        got.data_request  = out_ch.data_request;
        got.done_res      = out_ch.done_res;
        got.status        = out_ch.status;
        got.response_byte = out_ch.response_byte;
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result %0d expected none actual 0x%0h",
                   $realtime, results_seen, got);
        end else begin
          check_result(expected_results.pop_front(), got);
        end
        recv_gap = draw_gap(recv_idle_pct);
        if (results_seen == 200 || results_seen == 500) hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [LenW-1:0] lengths[3];
    dut_view      = reset_state();
    card_view     = reset_state();
    send_idle_pct = 30;
    recv_idle_pct = 30;
    wait (rst_ni === 1'b1);

    // field extremes, exchanges while idle, starts cutting each other short
    push_item('{ActExchange, 32'h0000_0000, 8'h00, 8'h00});
    push_item('{ActExchange, 32'hFFFF_FFFF, 8'hFF, 8'hFF});
    push_item('{ActInit, 32'hFFFF_FFFF, 8'hFF, 8'h00});
    repeat (3) queue_item(ActExchange);
    push_item('{ActRead, 32'h0000_0000, 8'hFF, 8'h00});
    repeat (12) queue_item(ActExchange);
    // carry one sector write through to the data response
    card_obliging = 1'b1;
    push_item('{ActWrite, 32'hFFFF_FFFF, 8'h00, 8'hFF});
    finish_transaction();
    card_obliging = 1'b0;
    drain();

    lengths = '{10'd1, 10'd0, LenW'($urandom_range(2, 24))};
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 20 : 60);
      recv_idle_pct = (p % 3 == 2) ? 0 : ((p % 3 == 0) ? 60 : 20);
      write_read_length(lengths[p]);
      random_phase(20);
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/sdspi_pkg.sv
hw/rtl/sdspi_if.sv
hw/rtl/sdspi_in_stage.sv
hw/rtl/sdspi_seq_core.sv
hw/rtl/sd_spi_host_sequencer.sv
tb/sv/tb_top.sv
